>>> rtl/core/fwia_pkg.sv
// Shared types, constants and functions for the fixed-width int to ASCII core.
package fwia_pkg;

    localparam int ValueW     = 16;
    localparam int CharW      = 7;
    localparam int DecDigits  = 5;
    localparam int HexChars   = 4;
    localparam int BcdW       = 4 * DecDigits;
    localparam int StepsPerStg = 4;
    localparam int NumStages  = ValueW / StepsPerStg;
    localparam int IdxW       = $clog2(DecDigits);

    localparam logic [CharW-1:0] AsciiZero = 7'd48;
    localparam logic [CharW-1:0] AsciiA    = 7'd65;

    localparam logic ModeHex = 1'b0;
    localparam logic ModeDec = 1'b1;

    typedef struct packed {
        logic [BcdW-1:0]   bcd;
        logic [ValueW-1:0] bin;
        logic [ValueW-1:0] val;
        logic              mode;
    } t_work;

    function automatic logic [CharW-1:0] char_of(input logic [3:0] d);
        logic [CharW-1:0] d7;
        d7 = {3'd0, d};
        if (d < 4'd10) begin
            char_of = AsciiZero + d7;
        end else begin
            char_of = AsciiA + d7 - 7'd10;
        end
    endfunction

endpackage

>>> rtl/core/fwia_if.sv
// Valid/ready channel interfaces for input values and output characters.
interface fwia_in_if;
    logic                          valid;
    logic                          ready;
    logic [fwia_pkg::ValueW-1:0]   value;
    logic                          mode;

    modport source (output valid, output value, output mode, input ready);
    modport sink   (input valid, input value, input mode, output ready);
endinterface

interface fwia_out_if;
    logic                          valid;
    logic                          ready;
    logic [fwia_pkg::CharW-1:0]    ascii_char;
    logic                          last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

>>> rtl/core/fwia_dabble_stage.sv
// One pipeline stage of the binary to BCD shift-add-3 conversion.
module fwia_dabble_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fwia_pkg::t_work i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output fwia_pkg::t_work o_data
);

    logic            r_valid;
    fwia_pkg::t_work r_data;
    fwia_pkg::t_work n_data;

    always_comb begin
        logic [fwia_pkg::BcdW-1:0]   bcd;
        logic [fwia_pkg::ValueW-1:0] bin;
        bcd = i_data.bcd;
        bin = i_data.bin;
        for (int s = 0; s < fwia_pkg::StepsPerStg; s++) begin
            for (int d = 0; d < fwia_pkg::DecDigits; d++) begin
                if (bcd[4*d +: 4] >= 4'd5) begin
                    bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
                end
            end
            {bcd, bin} = {bcd[fwia_pkg::BcdW-2:0], bin, 1'b0};
        end
        n_data      = i_data;
        n_data.bcd  = bcd;
        n_data.bin  = bin;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/core/fwia_serializer.sv
// Emits the converted value one ASCII character per word, flagging the last.
module fwia_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  fwia_pkg::t_work             i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [fwia_pkg::CharW-1:0]  o_ascii_char,
    output logic                        o_last
);

    logic                           r_valid;
    logic [fwia_pkg::IdxW-1:0]      r_idx;
    logic [fwia_pkg::BcdW-1:0]      r_bcd;
    logic [fwia_pkg::ValueW-1:0]    r_val;
    logic                           r_mode;
    logic [fwia_pkg::IdxW-1:0]      w_last_idx;
    logic [3:0]                     w_digit;
    logic [fwia_pkg::IdxW-1:0]      n_idx;

    assign w_last_idx = (r_mode == fwia_pkg::ModeDec)
                      ? fwia_pkg::IdxW'(fwia_pkg::DecDigits - 1)
                      : fwia_pkg::IdxW'(fwia_pkg::HexChars - 1);

    always_comb begin
        logic [fwia_pkg::BcdW-1:0]   bsh;
        logic [fwia_pkg::ValueW-1:0] vsh;
        bsh = r_bcd << {r_idx, 2'b00};
        vsh = r_val << {r_idx, 2'b00};
        if (r_mode == fwia_pkg::ModeDec) begin
            w_digit = bsh[fwia_pkg::BcdW-1 -: 4];
        end else begin
            w_digit = vsh[fwia_pkg::ValueW-1 -: 4];
        end
    end

    assign o_last       = (r_idx == w_last_idx);
    assign o_valid      = r_valid;
    assign o_ascii_char = fwia_pkg::char_of(w_digit);
    assign o_ready      = !r_valid || (i_ready && o_last);
    assign n_idx        = r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_idx   <= '0;
        end else if (i_ready) begin
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bcd  <= i_data.bcd;
            r_val  <= i_data.val;
            r_mode <= i_data.mode;
        end
    end

endmodule

>>> rtl/core/fixed_width_int_to_ascii_core.sv
// A value's first character is offered after it has passed the dabble stage registers and the serializer register.
// The BCD conversion runs through 4 register stages of 4 shift-add-3 steps each.
// Throughput: one character per cycle while the output is ready; a value gives 4 (hex)
// or 5 (decimal) characters, and the next value's first character can follow directly.
// Reset (synchronous, active low) clears all valid bits and the character index; data registers are not reset.
module fixed_width_int_to_ascii_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fwia_in_if.sink           i_in,
    fwia_out_if.source        o_out
);

    localparam int NStg = fwia_pkg::NumStages;

    logic            w_valid [0:NStg];
    logic            w_ready [0:NStg];
    fwia_pkg::t_work w_data  [0:NStg];

    assign w_valid[0]     = i_in.valid;
    assign i_in.ready     = w_ready[0];
    assign w_data[0].bcd  = '0;
    assign w_data[0].bin  = i_in.value;
    assign w_data[0].val  = i_in.value;
    assign w_data[0].mode = i_in.mode;

    for (genvar g = 0; g < NStg; g++) begin : g_stage
        fwia_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    fwia_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_valid[NStg]),
        .o_ready      (w_ready[NStg]),
        .i_data       (w_data[NStg]),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_ascii_char (o_out.ascii_char),
        .o_last       (o_out.last)
    );

endmodule
